[src/ccfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-checked command frame responder package
// Shared constants, command and ack codes, the CRC-16 byte update and the
// command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  // Reply words leave in chunks of this many bytes (1 to 8).
  localparam int CHUNK_WIDTH_BYTES = 8;
  localparam int FILL_W = (CHUNK_WIDTH_BYTES > 1) ? $clog2(CHUNK_WIDTH_BYTES) : 1;

  // Frame delimiters and CRC polynomial.
  localparam logic [7:0]  HOST_START    = 8'h2F;
  localparam logic [7:0]  REPLY_START   = 8'h2E;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // Fixed reply data.
  localparam logic [7:0]  PROTO_VERSION = 8'd107;
  localparam logic [15:0] IFACE_VERSION = 16'h0002;  // bytes 2, 0
  localparam logic [7:0]  FILL_BYTE     = 8'hFF;

  // Command codes.
  localparam logic [7:0] CMD_ALIVE       = 8'h30;
  localparam logic [7:0] CMD_PROTO_VER   = 8'h31;
  localparam logic [7:0] CMD_GET_NAME    = 8'h32;
  localparam logic [7:0] CMD_IFACE_VER   = 8'h33;
  localparam logic [7:0] CMD_EXIT        = 8'h34;
  localparam logic [7:0] CMD_INIT_FLASH  = 8'h37;
  localparam logic [7:0] CMD_READ        = 8'h3A;
  localparam logic [7:0] CMD_WRITE       = 8'h3B;
  localparam logic [7:0] CMD_SET_MODE    = 8'h3F;

  // Ack codes.
  localparam logic [7:0] ACK_OK          = 8'd0;
  localparam logic [7:0] ACK_UNKNOWN     = 8'd2;
  localparam logic [7:0] ACK_BAD_CRC     = 8'd4;

  // Mode register value after reset.
  localparam logic [7:0] MODE_RESET      = 8'd3;

  // Configuration register indexes.
  localparam logic CFG_SIGNATURE = 1'b0;
  localparam logic CFG_NAME      = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic rx_take;   // a host word is accepted this cycle
    logic gen_step;  // the reply generator emits one byte this cycle
  } ccfr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       frame_last;    // the offered host word closes a frame
    logic       flush_needed;  // the next reply byte completes a chunk
    logic       out_free;      // the output register can take a chunk
    logic       last_byte;     // the next reply byte is the final one
    logic [7:0] mode;          // current mode register
  } ccfr_status_t;

  // CRC-16, no reflection, one byte folded in, high bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[src/ccfr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Host byte channel
// Valid/ready channel carrying one received host byte and a session flag.
// ----------------------------------------------------------------------------
interface ccfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       session_start;

  modport source (output valid, rx_byte, session_start, input ready);
  modport sink   (input valid, rx_byte, session_start, output ready);
endinterface
`default_nettype wire

[src/ccfr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Reply chunk channel
// Valid/ready channel carrying one chunk of a reply frame.
// ----------------------------------------------------------------------------
interface ccfr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic        last_chunk;
  logic        close_link;

  modport source (output valid, chunk_data, chunk_bytes, last_chunk, close_link,
                  input ready);
  modport sink   (input valid, chunk_data, chunk_bytes, last_chunk, close_link,
                  output ready);
endinterface
`default_nettype wire

[src/ccfr_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface ccfr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/ccfr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Responder controller
// Alternates between taking host words and driving the reply generator.
// ----------------------------------------------------------------------------
module ccfr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ccfr_pkg::ccfr_status_t stat_i,
  output ccfr_pkg::ccfr_cmd_t    cmd_o
);
  import ccfr_pkg::*;

  typedef enum logic [0:0] {
    ST_RX,
    ST_REPLY
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  // Commands follow from the state and the handshakes.
  always_comb begin
    cmd_o.rx_take  = in_valid_i & in_ready_q;
    cmd_o.gen_step = (state_q == ST_REPLY) & (~stat_i.flush_needed | stat_i.out_free);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RX: begin
        if (cmd_o.rx_take && stat_i.frame_last) state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (cmd_o.gen_step && stat_i.last_byte) state_d = ST_RX;
      end
      default: state_d = ST_RX;
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_RX);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule
`default_nettype wire

[src/ccfr_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Responder datapath
// Frame parser with running CRC, reply byte generator with its own CRC,
// chunk packer and output register, plus the configuration registers.
// ----------------------------------------------------------------------------
module ccfr_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ccfr_pkg::ccfr_cmd_t    cmd_i,
  output ccfr_pkg::ccfr_status_t stat_o,
  input  logic [7:0]             rx_byte_i,
  input  logic                   session_start_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [63:0]            cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [63:0]            chunk_data_o,
  output logic [3:0]             chunk_bytes_o,
  output logic                   last_chunk_o,
  output logic                   close_link_o
);
  import ccfr_pkg::*;

  // Receive state.
  logic [8:0]  pos_q;
  logic [7:0]  cmd_q, len_q, fp_q, rcv_hi_q, mode_q;
  logic [15:0] addr_q, crc_q;

  // Configuration registers.
  logic [31:0] sig_q;
  logic [63:0] name_q;

  // Reply descriptor and generator.
  logic [7:0]  r_cmd_q, r_ack_q;
  logic [15:0] r_addr_q, r_crc_q;
  logic [8:0]  r_dlen_q, r_idx_q;
  logic [63:0] r_word_q;
  logic        r_fill_q, r_exit_q;

  // Chunk packer and output register.
  logic [63:0]       build_q;
  logic [FILL_W-1:0] fill_q;
  logic              out_valid_q;
  logic [63:0]       out_data_q;
  logic [3:0]        out_bytes_q;
  logic              out_last_q, out_close_q;

  // Parser decode for the offered word.
  logic [8:0]  pos_eff, len_full, crc_hi_pos;
  logic        skip, in_body, at_crc_hi, frame_last, crc_ok;
  logic [15:0] crc_base, crc_next;

  always_comb begin
    pos_eff    = session_start_i ? 9'd0 : pos_q;
    len_full   = (len_q == 8'd0) ? 9'd256 : {1'b0, len_q};
    crc_hi_pos = 9'd5 + len_full;
    skip       = (pos_eff == 9'd0) && (rx_byte_i != HOST_START);
    in_body    = (pos_eff < 9'd5) || (pos_eff < crc_hi_pos);
    at_crc_hi  = (pos_eff == crc_hi_pos);
    frame_last = ~skip & ~in_body & ~at_crc_hi;
    crc_base   = (pos_eff == 9'd0) ? 16'h0000 : crc_q;
    crc_next   = crc16_byte(crc_base, rx_byte_i);
    crc_ok     = ({rcv_hi_q, rx_byte_i} == crc_q);
  end

  // Reply descriptor chosen at the close of a frame.
  logic [15:0] d_addr;
  logic [8:0]  d_dlen;
  logic [63:0] d_word;
  logic        d_fill, d_exit, mode_upd;
  logic [7:0]  d_ack;

  always_comb begin
    d_addr   = addr_q;
    d_dlen   = 9'd0;
    d_word   = 64'd0;
    d_fill   = 1'b0;
    d_exit   = 1'b0;
    d_ack    = ACK_OK;
    mode_upd = 1'b0;
    if (!crc_ok) begin
      d_addr = 16'h0000;
      d_ack  = ACK_BAD_CRC;
    end else begin
      case (cmd_q)
        CMD_ALIVE, CMD_WRITE: begin
        end
        CMD_PROTO_VER: begin
          d_word = {56'd0, PROTO_VERSION};
          d_dlen = 9'd1;
        end
        CMD_GET_NAME: begin
          d_word = name_q;
          d_dlen = 9'd8;
        end
        CMD_IFACE_VER: begin
          d_word = {48'd0, IFACE_VERSION};
          d_dlen = 9'd2;
        end
        CMD_EXIT: begin
          d_exit = 1'b1;
        end
        CMD_SET_MODE: begin
          mode_upd = (len_q != 8'd0);
        end
        CMD_INIT_FLASH: begin
          d_word = {32'd0, (sig_q[7:0] != 8'd0) ? sig_q : 32'hFFFF_FFFF};
          d_dlen = 9'd4;
        end
        CMD_READ: begin
          // A zero length code or a zero count both give the full page.
          d_fill = 1'b1;
          d_dlen = (len_q == 8'd0 || fp_q == 8'd0) ? 9'd256 : {1'b0, fp_q};
        end
        default: d_ack = ACK_UNKNOWN;
      endcase
    end
  end

  // Reply byte at the generator index.
  logic [8:0]  data_end, data_off;
  logic [7:0]  gen_byte;
  logic        last_byte, crc_freeze, flush_needed, out_free;
  logic [63:0] build_ins;

  always_comb begin
    data_end   = 9'd5 + r_dlen_q;
    data_off   = r_idx_q - 9'd5;
    last_byte  = (r_idx_q == data_end + 9'd2);
    crc_freeze = (r_idx_q > data_end);
    case (r_idx_q)
      9'd0:    gen_byte = REPLY_START;
      9'd1:    gen_byte = r_cmd_q;
      9'd2:    gen_byte = r_addr_q[15:8];
      9'd3:    gen_byte = r_addr_q[7:0];
      9'd4:    gen_byte = r_dlen_q[7:0];
      default: begin
        if (r_idx_q < data_end) begin
          gen_byte = r_fill_q ? FILL_BYTE : r_word_q[{data_off[2:0], 3'b000} +: 8];
        end else if (r_idx_q == data_end) begin
          gen_byte = r_ack_q;
        end else if (r_idx_q == data_end + 9'd1) begin
          gen_byte = r_crc_q[15:8];
        end else begin
          gen_byte = r_crc_q[7:0];
        end
      end
    endcase
    flush_needed = (fill_q == FILL_W'(CHUNK_WIDTH_BYTES - 1)) || last_byte;
    out_free     = ~out_valid_q | out_ready_i;
    build_ins    = build_q;
    build_ins[{fill_q, 3'b000} +: 8] = gen_byte;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q  <= 32'd0;
      name_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIGNATURE: sig_q  <= cfg_data_i[31:0];
        CFG_NAME:      name_q <= cfg_data_i;
        default:       name_q <= name_q;
      endcase
    end
  end

  // Frame parser.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 9'd0;
      cmd_q    <= 8'd0;
      addr_q   <= 16'd0;
      len_q    <= 8'd0;
      fp_q     <= 8'd0;
      crc_q    <= 16'd0;
      rcv_hi_q <= 8'd0;
      mode_q   <= MODE_RESET;
    end else if (cmd_i.rx_take) begin
      if (skip) begin
        pos_q <= 9'd0;
      end else begin
        case (pos_eff)
          9'd1:    cmd_q         <= rx_byte_i;
          9'd2:    addr_q[15:8]  <= rx_byte_i;
          9'd3:    addr_q[7:0]   <= rx_byte_i;
          9'd4:    len_q         <= rx_byte_i;
          9'd5:    fp_q          <= rx_byte_i;
          default: fp_q          <= fp_q;
        endcase
        if (in_body) begin
          crc_q <= crc_next;
          pos_q <= pos_eff + 9'd1;
        end else if (at_crc_hi) begin
          rcv_hi_q <= rx_byte_i;
          pos_q    <= pos_eff + 9'd1;
        end else begin
          pos_q <= 9'd0;
          if (mode_upd) mode_q <= fp_q;
        end
      end
    end
  end

  // Reply descriptor latch; no reset needed, it is loaded before use.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take && frame_last) begin
      r_cmd_q  <= cmd_q;
      r_addr_q <= d_addr;
      r_dlen_q <= d_dlen;
      r_word_q <= d_word;
      r_fill_q <= d_fill;
      r_ack_q  <= d_ack;
      r_exit_q <= d_exit;
    end
  end

  // Reply generator, chunk packer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_idx_q     <= 9'd0;
      r_crc_q     <= 16'd0;
      build_q     <= 64'd0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= 64'd0;
      out_bytes_q <= 4'd0;
      out_last_q  <= 1'b0;
      out_close_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.rx_take && frame_last) begin
        r_idx_q <= 9'd0;
        r_crc_q <= 16'd0;
        build_q <= 64'd0;
        fill_q  <= '0;
      end else if (cmd_i.gen_step) begin
        r_idx_q <= r_idx_q + 9'd1;
        if (!crc_freeze) r_crc_q <= crc16_byte(r_crc_q, gen_byte);
        if (flush_needed) begin
          out_valid_q <= 1'b1;
          out_data_q  <= build_ins;
          out_bytes_q <= 4'(fill_q) + 4'd1;
          out_last_q  <= last_byte;
          out_close_q <= last_byte & r_exit_q;
          build_q     <= 64'd0;
          fill_q      <= '0;
        end else begin
          build_q <= build_ins;
          fill_q  <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat_o.frame_last   = frame_last;
    stat_o.flush_needed = flush_needed;
    stat_o.out_free     = out_free;
    stat_o.last_byte    = last_byte;
    stat_o.mode         = mode_q;
  end

  assign out_valid_o   = out_valid_q;
  assign chunk_data_o  = out_data_q;
  assign chunk_bytes_o = out_bytes_q;
  assign last_chunk_o  = out_last_q;
  assign close_link_o  = out_close_q;

endmodule
`default_nettype wire

[src/crc_checked_command_frame_responder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-checked command frame responder
// Parses CRC-16 checked host command frames one byte a word and sends the
// reply frame as chunks of up to eight bytes.
// ----------------------------------------------------------------------------
// Flow: host bytes are taken on a registered ready. After the last CRC byte the
//   reply is built one byte a cycle while each full chunk finds the output free.
// Input: one host byte per cycle inside and between frames; a reply of N bytes
//   (8 to 264) holds the input until its final byte has been generated.
// Reset: asynchronous, active low; parser idle, mode 3, registers cleared.
module crc_checked_command_frame_responder (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccfr_in_if.sink    cmd_i,
  ccfr_out_if.source chunk_o,
  ccfr_cfg_if.sink   cfg_i
);
  import ccfr_pkg::*;

  ccfr_cmd_t    cmd;
  ccfr_status_t stat;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  ccfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rx_byte_i       (cmd_i.rx_byte),
    .session_start_i (cmd_i.session_start),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (chunk_o.ready),
    .out_valid_o     (chunk_o.valid),
    .chunk_data_o    (chunk_o.chunk_data),
    .chunk_bytes_o   (chunk_o.chunk_bytes),
    .last_chunk_o    (chunk_o.last_chunk),
    .close_link_o    (chunk_o.close_link)
  );

  // Host words are never taken while a reply is being generated.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.gen_step |-> !cmd_i.ready)
    else $error("host input ready during reply generation");

  // The final reply byte hands the block back to the host side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd.gen_step && stat.last_byte) |=> cmd_i.ready)
    else $error("input not reopened after the final reply byte");

  // The mode register only changes when a frame closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (stat.mode != $past(stat.mode)) |-> $past(cmd.rx_take && stat.frame_last))
    else $error("mode changed outside a frame close");

endmodule
`default_nettype wire

[tb/crc_checked_command_frame_responder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-checked command frame responder
// Host frames go in one byte per word: first a table of directed frames and
// register writes, then random frames with noise, broken frames and session
// restarts. A local parser and reply builder predicts every reply chunk, and
// each chunk is compared field by field. For the table rows, the reply length
// and ack code are also checked against values typed into the table.
// ----------------------------------------------------------------------------
module crc_checked_command_frame_responder_test;
  import ccfr_pkg::*;

  // Frame layout and reply contents.
  localparam logic [7:0]  SOF_HOST      = 8'h2F;
  localparam logic [7:0]  SOF_REPLY     = 8'h2E;
  localparam logic [15:0] CRC16_POLY    = 16'h1021;
  localparam logic [7:0]  PROTO_NUMBER  = 8'd107;
  localparam logic [7:0]  FILL_VALUE    = 8'hFF;
  localparam logic [7:0]  CMD_UNUSED_LO = 8'h00;
  localparam logic [7:0]  CMD_UNUSED_HI = 8'hFF;
  localparam int          MAX_REPLY     = 264;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {LEAD_NONE, LEAD_NOISE, LEAD_PARTIAL} lead_e;

  // One directed row: a frame, or a register write.
  typedef struct {
    row_kind_e   kind;
    logic        cfg_idx;
    logic [63:0] cfg_val;
    logic [7:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  len_code;
    logic [7:0]  param;
    bit          crc_ok;
    lead_e       lead;
    int          exp_len;   // 0 leaves the reply to the predictor alone
    logic [7:0]  exp_ack;
  } row_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        close;
  } chunk_word_t;

  typedef struct {
    bit         typed;
    int         exp_len;
    logic [7:0] exp_ack;
  } reply_note_t;

  logic clk;
  logic rst_n;

  ccfr_in_if  cmd_if ();
  ccfr_out_if chunk_if ();
  ccfr_cfg_if cfg_if ();

  crc_checked_command_frame_responder DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_if),
    .chunk_o (chunk_if),
    .cfg_i   (cfg_if)
  );

  // Predicted parser state and registers.
  logic [8:0]  frame_pos;
  logic [7:0]  frame_cmd;
  logic [15:0] frame_addr;
  logic [7:0]  frame_len;
  logic [7:0]  frame_param;
  logic [15:0] frame_crc;
  logic [15:0] got_crc;
  logic [7:0]  mode_reg;
  logic [31:0] sig_reg;
  logic [63:0] name_reg;

  chunk_word_t pending_chunks[$];
  reply_note_t reply_notes[$];
  row_t        dir_rows[$];

  // Typed expectation of the table row now being sent.
  bit          row_typed;
  int          row_exp_len;
  logic [7:0]  row_exp_ack;

  logic [7:0]  rx_reply [MAX_REPLY];
  int          rx_count;
  int          err_count;
  int          items_sent;
  int          replies_made;
  bit          src_quiet;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Fail the run if it hangs.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // CRC-16, one message bit at a time, most significant bit first.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Takes one accepted host byte; on a completed frame it queues the reply chunks.
  task automatic absorb_host_byte(input logic [7:0] b, input logic ss);
    logic [7:0]  rep [MAX_REPLY];
    logic [7:0]  dbytes [8];
    logic [7:0]  ack;
    logic [7:0]  r_cmd;
    logic [15:0] r_addr;
    logic [15:0] c;
    int          total;
    int          dlen;
    int          n;
    int          cnt;
    bit          fill;
    bit          closing;
    chunk_word_t w;
    reply_note_t note;

    if (ss) frame_pos = '0;
    if (frame_pos == 0) begin
      if (b != SOF_HOST) return;
      frame_crc = '0;
    end
    case (frame_pos)
      9'd1: frame_cmd = b;
      9'd2: frame_addr[15:8] = b;
      9'd3: frame_addr[7:0] = b;
      9'd4: frame_len = b;
      9'd5: frame_param = b;
      default: ;
    endcase
    total = 7 + ((frame_len == 0) ? 256 : int'(frame_len));

    // Header and payload feed the CRC; the two CRC bytes are collected.
    if (frame_pos < 5 || int'(frame_pos) < total - 2) begin
      frame_crc = crc16_fold(frame_crc, b);
      frame_pos = frame_pos + 9'd1;
      return;
    end
    if (int'(frame_pos) == total - 2) begin
      got_crc   = {b, 8'h00};
      frame_pos = frame_pos + 9'd1;
      return;
    end
    got_crc[7:0] = b;
    frame_pos    = '0;

    // Decide the reply contents.
    ack     = ACK_OK;
    r_cmd   = frame_cmd;
    r_addr  = frame_addr;
    dlen    = 0;
    fill    = 1'b0;
    closing = 1'b0;
    if (got_crc != frame_crc) begin
      ack    = ACK_BAD_CRC;
      r_addr = '0;
    end else begin
      case (frame_cmd)
        CMD_ALIVE, CMD_WRITE: ;
        CMD_PROTO_VER: begin
          dlen      = 1;
          dbytes[0] = PROTO_NUMBER;
        end
        CMD_GET_NAME: begin
          dlen = 8;
          for (int k = 0; k < 8; k++) dbytes[k] = name_reg[8*k +: 8];
        end
        CMD_IFACE_VER: begin
          dlen      = 2;
          dbytes[0] = 8'd2;
          dbytes[1] = 8'd0;
        end
        CMD_EXIT: closing = 1'b1;
        CMD_SET_MODE: begin
          if (frame_len != 0) mode_reg = frame_param;
        end
        CMD_INIT_FLASH: begin
          dlen = 4;
          for (int k = 0; k < 4; k++)
            dbytes[k] = (sig_reg[7:0] != 0) ? sig_reg[8*k +: 8] : FILL_VALUE;
        end
        CMD_READ: begin
          fill = 1'b1;
          dlen = (frame_len == 0 || frame_param == 0) ? 256 : int'(frame_param);
        end
        default: ack = ACK_UNKNOWN;
      endcase
    end

    // Assemble the reply frame and its trailing CRC.
    rep[0] = SOF_REPLY;
    rep[1] = r_cmd;
    rep[2] = r_addr[15:8];
    rep[3] = r_addr[7:0];
    rep[4] = 8'(dlen);
    n = 5;
    for (int i = 0; i < dlen; i++) begin
      rep[n] = fill ? FILL_VALUE : dbytes[i];
      n++;
    end
    rep[n] = ack;
    n++;
    c = '0;
    for (int i = 0; i < n; i++) c = crc16_fold(c, rep[i]);
    rep[n]     = c[15:8];
    rep[n + 1] = c[7:0];
    n = n + 2;

    // Cut it into chunks.
    for (int off = 0; off < n; off += CHUNK_WIDTH_BYTES) begin
      cnt = n - off;
      if (cnt > CHUNK_WIDTH_BYTES) cnt = CHUNK_WIDTH_BYTES;
      w.data = '0;
      for (int i = 0; i < cnt; i++) w.data[8*i +: 8] = rep[off + i];
      w.nbytes = 4'(cnt);
      w.last   = (off + cnt >= n);
      w.close  = w.last && closing;
      pending_chunks.push_back(w);
    end
    note.typed   = row_typed;
    note.exp_len = row_exp_len;
    note.exp_ack = row_exp_ack;
    reply_notes.push_back(note);
    row_typed = 1'b0;
    replies_made++;
  endtask

  // Gap before a host word: mostly none or short, now and then long.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_cfg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & ~64'hFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Entered and left at a falling edge; valid is low again when it returns.
  task automatic send_byte(input logic [7:0] b, input logic ss);
    int gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid         = 1'b1;
    cmd_if.rx_byte       = b;
    cmd_if.session_start = ss;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    absorb_host_byte(b, ss);
    @(negedge clk);
    cmd_if.valid = 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] addr,
                            input logic [7:0] len_code, input logic [7:0] param,
                            input bit crc_ok, input lead_e lead, input bit ss_first);
    logic [7:0]  fb[$];
    logic [7:0]  nb;
    logic [15:0] c;
    int          plen;
    bit          ss0;

    ss0 = ss_first;
    // Optional lead-in: stray bytes, or a frame cut short by a session restart.
    if (lead == LEAD_NOISE) begin
      repeat ($urandom_range(1, 4)) begin
        nb = 8'($urandom_range(0, 255));
        if (nb == SOF_HOST) nb = ~nb;
        send_byte(nb, 1'($urandom_range(0, 1)));
      end
    end else if (lead == LEAD_PARTIAL) begin
      send_byte(SOF_HOST, 1'b0);
      items_sent++;
      repeat ($urandom_range(1, 5)) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        items_sent++;
      end
      ss0 = 1'b1;
    end

    fb.push_back(SOF_HOST);
    fb.push_back(cmd);
    fb.push_back(addr[15:8]);
    fb.push_back(addr[7:0]);
    fb.push_back(len_code);
    plen = (len_code == 0) ? 256 : int'(len_code);
    fb.push_back(param);
    for (int k = 1; k < plen; k++) fb.push_back(8'($urandom_range(0, 255)));
    c = '0;
    foreach (fb[k]) c = crc16_fold(c, fb[k]);
    if (!crc_ok) c = c ^ 16'($urandom_range(1, 65535));
    fb.push_back(c[15:8]);
    fb.push_back(c[7:0]);

    foreach (fb[k]) begin
      send_byte(fb[k], (k == 0) ? ss0 : 1'b0);
      items_sent++;
    end
  endtask

  task automatic cfg_write(input logic idx, input logic [63:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_SIGNATURE) sig_reg = val[31:0];
    else name_reg = val;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Wait for every predicted chunk, then let the block settle.
  task automatic wait_drained();
    while (pending_chunks.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Reply side pacing: random stalls, mostly short, with quiet stretches.
  initial begin : sink_pacing
    int stall_left;
    int r;
    bit quiet;
    stall_left     = 0;
    quiet          = 1'b0;
    chunk_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) quiet = !quiet;
      if (stall_left > 0) begin
        chunk_if.ready = 1'b0;
        stall_left--;
      end else begin
        chunk_if.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!quiet) begin
          if (r < 25) stall_left = $urandom_range(1, 3);
          else if (r < 29) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Check each accepted reply word against the oldest prediction.
  always @(posedge clk) begin : chunk_check
    chunk_word_t w;
    reply_note_t note;
    if (rst_n && chunk_if.valid && chunk_if.ready) begin
      if (pending_chunks.size() == 0) begin
        report_mismatch("unexpected chunk", chunk_if.chunk_data, '0);
      end else begin
        w = pending_chunks.pop_front();
        if (chunk_if.chunk_data !== w.data)
          report_mismatch("chunk_data", chunk_if.chunk_data, w.data);
        if (chunk_if.chunk_bytes !== w.nbytes)
          report_mismatch("chunk_bytes", 64'(chunk_if.chunk_bytes), 64'(w.nbytes));
        if (chunk_if.last_chunk !== w.last)
          report_mismatch("last_chunk", 64'(chunk_if.last_chunk), 64'(w.last));
        if (chunk_if.close_link !== w.close)
          report_mismatch("close_link", 64'(chunk_if.close_link), 64'(w.close));
      end

      // Gather the reply bytes for the typed checks of the table rows.
      for (int i = 0; i < CHUNK_WIDTH_BYTES; i++) begin
        if (i < int'(chunk_if.chunk_bytes) && rx_count < MAX_REPLY) begin
          rx_reply[rx_count] = chunk_if.chunk_data[8*i +: 8];
          rx_count++;
        end
      end
      if (chunk_if.last_chunk === 1'b1) begin
        if (reply_notes.size() != 0) begin
          note = reply_notes.pop_front();
          if (note.typed) begin
            if (rx_count != note.exp_len)
              report_mismatch("reply length", 64'(rx_count), 64'(note.exp_len));
            else if (rx_reply[rx_count - 3] !== note.exp_ack)
              report_mismatch("ack code", 64'(rx_reply[rx_count - 3]), 64'(note.exp_ack));
          end
        end
        rx_count = 0;
      end
    end
  end

  initial begin : stimulus
    row_t        r;
    logic [7:0]  rcmd;
    logic [7:0]  rlen;
    logic [7:0]  rparam;
    lead_e       rlead;
    int          pick;
    int          start_items;
    int          start_replies;
    int          guard;

    cmd_if.valid         = 1'b0;
    cmd_if.rx_byte       = '0;
    cmd_if.session_start = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_SIGNATURE;
    cfg_if.data          = '0;
    rst_n                = 1'b0;
    frame_pos            = '0;
    frame_cmd            = '0;
    frame_addr           = '0;
    frame_len            = '0;
    frame_param          = '0;
    frame_crc            = '0;
    got_crc              = '0;
    mode_reg             = MODE_RESET;
    sig_reg              = '0;
    name_reg             = '0;
    row_typed            = 1'b0;
    row_exp_len          = 0;
    row_exp_ack          = '0;
    rx_count             = 0;
    err_count            = 0;
    items_sent           = 0;
    replies_made         = 0;
    src_quiet            = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows: kind, reg, value, cmd, addr, len, param, crc ok, lead, length, ack.
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_ALIVE, 16'h0000,
                              8'd1, 8'h00, 1'b1, LEAD_NOISE, 8, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_PROTO_VER, 16'hFFFF,
                              8'd1, 8'hFF, 1'b1, LEAD_NONE, 9, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_GET_NAME, 16'h1234,
                              8'd1, 8'h5A, 1'b1, LEAD_NONE, 16, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_IFACE_VER, 16'h8001,
                              8'd2, 8'hFF, 1'b1, LEAD_NONE, 10, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_INIT_FLASH, 16'h00FF,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 12, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_READ, 16'h4000,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 264, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_READ, 16'h4001,
                              8'd3, 8'h05, 1'b1, LEAD_NONE, 13, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_READ, 16'h4002,
                              8'd2, 8'h01, 1'b1, LEAD_NONE, 9, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_READ, 16'h4003,
                              8'd1, 8'hFF, 1'b1, LEAD_NONE, 263, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_WRITE, 16'h7FFF,
                              8'd4, 8'h11, 1'b1, LEAD_NONE, 8, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_SET_MODE, 16'h0000,
                              8'd1, 8'hAA, 1'b1, LEAD_NONE, 8, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_SET_MODE, 16'h0000,
                              8'd2, 8'h01, 1'b1, LEAD_NONE, 8, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_UNUSED_LO, 16'h0101,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 8, ACK_UNKNOWN});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_UNUSED_HI, 16'hFEFE,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 8, ACK_UNKNOWN});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_ALIVE, 16'hBEEF,
                              8'd1, 8'h00, 1'b0, LEAD_NONE, 8, ACK_BAD_CRC});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_READ, 16'hCAFE,
                              8'd1, 8'h00, 1'b0, LEAD_NONE, 8, ACK_BAD_CRC});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_PROTO_VER, 16'h0F0F,
                              8'd3, 8'h22, 1'b1, LEAD_PARTIAL, 9, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_EXIT, 16'h2222,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 8, ACK_OK});
    dir_rows.push_back(row_t'{ROW_CFG, CFG_SIGNATURE, 64'hFFFF_FFFF, 8'h00, 16'h0000,
                              8'd0, 8'h00, 1'b1, LEAD_NONE, 0, ACK_OK});
    dir_rows.push_back(row_t'{ROW_CFG, CFG_NAME, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 16'h0000,
                              8'd0, 8'h00, 1'b1, LEAD_NONE, 0, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_INIT_FLASH, 16'h3333,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 12, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_GET_NAME, 16'h4444,
                              8'd2, 8'h00, 1'b1, LEAD_NONE, 16, ACK_OK});
    dir_rows.push_back(row_t'{ROW_CFG, CFG_SIGNATURE, 64'hA5A5_A500, 8'h00, 16'h0000,
                              8'd0, 8'h00, 1'b1, LEAD_NONE, 0, ACK_OK});
    dir_rows.push_back(row_t'{ROW_CFG, CFG_NAME, 64'h4847_4645_4443_4241, 8'h00, 16'h0000,
                              8'd0, 8'h00, 1'b1, LEAD_NONE, 0, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_INIT_FLASH, 16'h5555,
                              8'd1, 8'h00, 1'b1, LEAD_NONE, 12, ACK_OK});
    dir_rows.push_back(row_t'{ROW_FRAME, CFG_SIGNATURE, 64'h0, CMD_GET_NAME, 16'h6666,
                              8'd1, 8'h00, 1'b0, LEAD_NONE, 8, ACK_BAD_CRC});

    // Walk the directed rows.
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        wait_drained();
        cfg_write(r.cfg_idx, r.cfg_val);
      end else begin
        src_quiet   = (i % 3 == 0);
        row_typed   = (r.exp_len != 0);
        row_exp_len = r.exp_len;
        row_exp_ack = r.exp_ack;
        send_frame(r.cmd, r.addr, r.len_code, r.param, r.crc_ok, r.lead, 1'b0);
      end
    end

    // Random phases, each under fresh register settings.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      cfg_write(CFG_SIGNATURE, pick_cfg());
      cfg_write(CFG_NAME, pick_cfg());
      start_items   = items_sent;
      start_replies = replies_made;
      while (items_sent - start_items < 30 || replies_made - start_replies < 3) begin
        case ($urandom_range(0, 11))
          0: rcmd = CMD_ALIVE;
          1: rcmd = CMD_PROTO_VER;
          2: rcmd = CMD_GET_NAME;
          3: rcmd = CMD_IFACE_VER;
          4: rcmd = CMD_EXIT;
          5: rcmd = CMD_INIT_FLASH;
          6, 7: rcmd = CMD_READ;
          8: rcmd = CMD_WRITE;
          9: rcmd = CMD_SET_MODE;
          default: rcmd = 8'($urandom_range(0, 255));
        endcase
        // Mostly short payloads, now and then a longer one.
        pick = $urandom_range(0, 39);
        if (pick < 3) rlen = 8'($urandom_range(9, 24));
        else rlen = 8'($urandom_range(1, 8));
        rparam = 8'($urandom_range(0, 255));
        if (rcmd == CMD_READ) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) rparam = 8'd0;
          else if (pick > 1) rparam = 8'($urandom_range(1, 16));
        end
        pick = $urandom_range(0, 11);
        if (pick < 2) rlead = LEAD_NOISE;
        else if (pick == 2) rlead = LEAD_PARTIAL;
        else rlead = LEAD_NONE;
        src_quiet = ($urandom_range(0, 3) == 0);
        send_frame(rcmd, 16'($urandom_range(0, 65535)), rlen, rparam,
                   $urandom_range(0, 7) != 0, rlead, $urandom_range(0, 7) == 0);
      end
    end

    // Drain the remaining replies.
    cmd_if.valid = 1'b0;
    guard = 0;
    while (pending_chunks.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending_chunks.size() != 0)
      report_mismatch("chunks never delivered", 64'(pending_chunks.size()), 64'd0);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ccfr_pkg.sv
src/ccfr_in_if.sv
src/ccfr_out_if.sv
src/ccfr_cfg_if.sv
src/ccfr_ctrl.sv
src/ccfr_datapath.sv
src/crc_checked_command_frame_responder.sv
tb/crc_checked_command_frame_responder_test.sv
